FILE: sv/dwgs_pkg.sv
`default_nettype none
package dwgs_pkg;

  localparam int DEFAULT_VALUE_WIDTH = 32;
  localparam logic [7:0] DEFAULT_SEPARATOR = 8'd44;  // comma
  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam int GROUP_SIZE = 3;
  localparam int CFG_ADDR_W = 3;
  localparam logic [0:0] REG_SEPARATOR = 1'b0;

  // Decimal digits needed for 2^w - 1: floor(w * log10(2)) + 1,
  // with log10(2) taken as 1233 / 4096 (exact enough up to 64 bits).
  function automatic int digit_count(input int w);
    int d;
    begin
      d = ((w * 1233) >> 12) + 1;
      return d;
    end
  endfunction

  // Controls for the double-dabble digit register.
  typedef struct packed {
    logic clear;
    logic shift_bit;
    logic bit_in;
    logic shift_digit;
  } bcd_ctrl_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SKIP = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_SPARE = 5'b10000
  } state_t;

endpackage
`default_nettype wire

FILE: sv/dwgs_bcd.sv
`default_nettype none
module dwgs_bcd
  import dwgs_pkg::*;
#(
  parameter int NDIGITS = digit_count(DEFAULT_VALUE_WIDTH)
) (
  input  wire logic       clk,
  input  wire bcd_ctrl_t  ctrl,
  output logic [3:0]      top_digit
);

  localparam int BW = 4 * NDIGITS;

  logic [BW-1:0] bcd;
  logic [BW-1:0] adj;

  // Add three to every digit of five or more before the next doubling.
  always_comb begin
    for (int i = 0; i < NDIGITS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      bcd <= '0;
    end else if (ctrl.shift_bit) begin
      bcd <= {adj[BW-2:0], ctrl.bit_in};
    end else if (ctrl.shift_digit) begin
      bcd <= {bcd[BW-5:0], 4'd0};
    end
  end

  assign top_digit = bcd[BW-1 -: 4];

endmodule
`default_nettype wire

FILE: sv/decimal_with_group_separators.sv
// Operation: VALUE_WIDTH bits are converted bit-serially, leading zero digits are dropped,
//   and the characters (digits and separators) are sent one by one through the output
//   register, which m_tready can stall.
// One value at a time: the next transfer is taken once the last character sits in the
//   output register.
// Reset (rst, synchronous, active high) returns to idle, empties the output register
//   and sets the separator to comma.
`default_nettype none
module decimal_with_group_separators
  import dwgs_pkg::*;
#(
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // Input stream: one number per transfer
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // s_tdata: value (low VALUE_WIDTH bits used)
  input  wire logic [((VALUE_WIDTH > 32) ? ((VALUE_WIDTH + 7) / 8) * 8 : 32)-1:0] s_tdata,
  // Output stream: one character per transfer
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [7:0]                     m_tdata,   // text_char
  output logic                           m_tlast,   // last
  // Configuration port
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [CFG_ADDR_W-1:0]     paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int NDIGITS = digit_count(VALUE_WIDTH);
  localparam int CNT_W = $clog2(VALUE_WIDTH);
  localparam int REM_W = $clog2(NDIGITS + 1);
  localparam logic [1:0] GRP_INIT = 2'(NDIGITS % GROUP_SIZE);

  // Separator register
  logic [7:0] separator;
  logic [7:0] sep_eff;

  assign pready = 1'b1;
  assign prdata = {24'd0, separator};

  always_ff @(posedge clk) begin
    if (rst) begin
      separator <= DEFAULT_SEPARATOR;
    end else if (psel && penable && pwrite && (paddr[2] == REG_SEPARATOR)) begin
      separator <= pwdata[7:0];
    end
  end

  // A zero separator stands for the default comma.
  assign sep_eff = (separator == 8'd0) ? DEFAULT_SEPARATOR : separator;

  // Sequencer registers
  state_t                 state, state_next;
  logic [VALUE_WIDTH-1:0] val, val_next;
  logic [CNT_W-1:0]       cnt, cnt_next;
  logic [REM_W-1:0]       rem, rem_next;      // digits still in the BCD register
  logic [1:0]             grp, grp_next;      // rem modulo three
  logic                   sep_pend, sep_pend_next;
  logic                   out_valid, out_valid_next;
  logic [7:0]             out_char, out_char_next;
  logic                   out_last, out_last_next;

  bcd_ctrl_t  bcd_ctrl;
  logic [3:0] top_digit;
  logic       in_xfer;
  logic       out_free;
  logic [1:0] grp_dec;

  dwgs_bcd #(
    .NDIGITS (NDIGITS)
  ) u_bcd (
    .clk       (clk),
    .ctrl      (bcd_ctrl),
    .top_digit (top_digit)
  );

  assign s_tready = (state == ST_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  // The output register can take a character when empty or being drained.
  assign out_free = !out_valid || m_tready;
  assign grp_dec  = (grp == 2'd0) ? 2'd2 : grp - 2'd1;

  always_comb begin
    state_next     = state;
    val_next       = val;
    cnt_next       = cnt;
    rem_next       = rem;
    grp_next       = grp;
    sep_pend_next  = sep_pend;
    out_valid_next = out_valid && !m_tready;
    out_char_next  = out_char;
    out_last_next  = out_last;
    bcd_ctrl       = '0;

    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          // Take the number and clear the digit register.
          val_next       = s_tdata[VALUE_WIDTH-1:0];
          cnt_next       = '0;
          bcd_ctrl.clear = 1'b1;
          state_next     = ST_CONV;
        end
      end
      ST_CONV: begin
        // Double-dabble: one binary bit into the digit register each cycle.
        bcd_ctrl.shift_bit = 1'b1;
        bcd_ctrl.bit_in    = val[VALUE_WIDTH-1];
        val_next           = {val[VALUE_WIDTH-2:0], 1'b0};
        cnt_next           = cnt + 1'b1;
        if (cnt == CNT_W'(VALUE_WIDTH - 1)) begin
          rem_next      = REM_W'(NDIGITS);
          grp_next      = GRP_INIT;
          sep_pend_next = 1'b0;
          state_next    = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop leading zero digits, keeping at least one digit.
        if (top_digit == 4'd0 && rem != REM_W'(1)) begin
          bcd_ctrl.shift_digit = 1'b1;
          rem_next             = rem - 1'b1;
          grp_next             = grp_dec;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          if (sep_pend) begin
            out_char_next = sep_eff;
            out_last_next = 1'b0;
            sep_pend_next = 1'b0;
          end else begin
            out_char_next = ASCII_ZERO + {4'd0, top_digit};
            out_last_next = (rem == REM_W'(1));
            if (rem == REM_W'(1)) begin
              state_next = ST_IDLE;
            end else begin
              // Advance to the next digit; a separator follows when the
              // digits left form whole groups of three.
              bcd_ctrl.shift_digit = 1'b1;
              rem_next             = rem - 1'b1;
              grp_next             = grp_dec;
              sep_pend_next        = (grp_dec == 2'd0);
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      sep_pend  <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      sep_pend  <= sep_pend_next;
    end
  end

  // Payload and counters hold their value outside their state; no reset.
  always_ff @(posedge clk) begin
    val      <= val_next;
    cnt      <= cnt_next;
    rem      <= rem_next;
    grp      <= grp_next;
    out_char <= out_char_next;
    out_last <= out_last_next;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_char;
  assign m_tlast  = out_last;

endmodule
`default_nettype wire
